>>> hdl/flptm_pkg.sv
// Shared types and constants for the four-level page table mapper.
// No dependencies; imported by the table store and the top level.
`default_nettype none

package flptm_pkg;

  localparam int unsigned IDX_W            = 9;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned VPAGE_W          = 36;
  localparam int unsigned FRAME_W          = 40;
  localparam int unsigned ENTRY_W          = 41;
  localparam int unsigned PRESENT_BIT      = 40;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned LEVEL_W          = 2;
  localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_MEM     = 2'd1,
    STAT_NOT_MAPPED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Pick the 9-bit table index of one level; level 3 is the root.
  function automatic logic [IDX_W-1:0] level_index(input logic [VPAGE_W-1:0] vpage,
                                                   input logic [LEVEL_W-1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd3:    idx = vpage[35:27];
      2'd2:    idx = vpage[26:18];
      2'd1:    idx = vpage[17:9];
      default: idx = vpage[8:0];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hdl/flptm_store.sv
// Table page store: one write port, one read port with registered data.
// Depends on flptm_pkg for the entry type.
`default_nettype none

module flptm_store
  import flptm_pkg::*;
#(
  parameter int unsigned ADDR_W = 15
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [ADDR_W-1:0] waddr_i,
  input  wire entry_t      wdata_i,
  input  wire              re_i,
  input  wire [ADDR_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [2**ADDR_W];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/four_level_page_table_mapper.sv
// Top level of the four-level page table mapper: sequencer and output register.
// Depends on flptm_pkg and instantiates flptm_store.
`default_nettype none

// Keeps a four-level radix page table for 48-bit virtual addresses in an on-chip
// store of NUM_TABLE_PAGES table pages of 512 entries each, page 0 being the root.
// A request carries a command in tuser (map, unmap, check) and the virtual page and
// physical frame in tdata; each request returns one result with a status and, for
// check, the present flag of the leaf. Map takes fresh table pages from a bump
// allocator wherever an upper entry is empty and reports out of table pages when
// the pool runs dry (pages already taken stay in place). After reset the store is
// swept to zero, one entry per cycle, over all NUM_TABLE_PAGES*512 entries (32768
// at the default size); no request is accepted during the sweep. A new request is
// accepted only in S_IDLE, once the previous result has gone to the output register.
// The walk visits up to four levels in turn, stopping early at a missing upper entry
// unless map links a fresh page there; an unused command code skips the walk.
// Each visit takes an address state (S_READ) and an evaluate state (S_EVAL) because
// the table memory's single read port is registered and each level's address needs
// the entry read at the level above; S_DONE then loads the output register. The
// next request is accepted while a finished result still waits in the output
// register; a second finished result holds the sequencer until the first is taken.

module four_level_page_table_mapper
  import flptm_pkg::*;
#(
  parameter int unsigned NUM_TABLE_PAGES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [79:0]  s_axis_tdata,   // [35:0] virt_page, [75:36] phys_frame, zero pad
  input  wire [1:0]   s_axis_tuser,   // [1:0] cmd
  // result channel
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [1:0] status, [2] is_mapped, zero pad
);

  localparam int unsigned PAGE_W = (NUM_TABLE_PAGES > 1) ? $clog2(NUM_TABLE_PAGES) : 1;
  localparam int unsigned ADDR_W = PAGE_W + IDX_W;
  localparam int unsigned DEPTH  = NUM_TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned FREE_W = $clog2(NUM_TABLE_PAGES + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [VPAGE_W-1:0]  vpage_q, vpage_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [FREE_W-1:0]   free_q, free_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                mapped_q, mapped_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_mapped_q, out_mapped_d;

  // table store port signals
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  entry_t              mem_rdata;

  logic                link_ok;
  logic                pool_empty;

  flptm_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // An upper entry links onward only if present and pointing at a table page in the store.
  assign link_ok    = mem_rdata[PRESENT_BIT] &&
                      (mem_rdata[FRAME_W-1:0] < FRAME_W'(NUM_TABLE_PAGES));
  assign pool_empty = (free_q >= FREE_W'(NUM_TABLE_PAGES));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_mapped_q, out_status_q};

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    vpage_d      = vpage_q;
    frame_d      = frame_q;
    level_d      = level_q;
    page_d       = page_q;
    addr_d       = addr_q;
    free_d       = free_q;
    clr_d        = clr_q;
    status_d     = status_q;
    mapped_d     = mapped_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_mapped_d = out_mapped_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = {page_q, level_index(vpage_q, level_q)};

    unique case (state_q)
      S_CLEAR: begin
        // sweep the store to empty entries
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          vpage_d  = s_axis_tdata[35:0];
          frame_d  = s_axis_tdata[75:36];
          level_d  = LEVEL_ROOT;
          page_d   = '0;
          status_d = STAT_OK;
          mapped_d = 1'b0;
          if ((s_axis_tuser == CMD_MAP) || (s_axis_tuser == CMD_UNMAP) ||
              (s_axis_tuser == CMD_CHECK)) begin
            state_d = S_READ;
          end else begin
            // unused code: drop it with a plain success result
            state_d = S_DONE;
          end
        end
      end

      S_READ: begin
        mem_re  = 1'b1;
        addr_d  = mem_raddr;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        if (level_q != LEVEL_LEAF) begin
          if (link_ok) begin
            page_d  = mem_rdata[PAGE_W-1:0];
            level_d = level_q - LEVEL_W'(1);
            state_d = S_READ;
          end else if (cmd_q == CMD_MAP) begin
            if (pool_empty) begin
              status_d = STAT_NO_MEM;
              state_d  = S_DONE;
            end else begin
              // link a fresh page; the sweep left it empty
              mem_we    = 1'b1;
              mem_wdata = {1'b1, FRAME_W'(free_q)};
              page_d    = free_q[PAGE_W-1:0];
              free_d    = free_q + FREE_W'(1);
              level_d   = level_q - LEVEL_W'(1);
              state_d   = S_READ;
            end
          end else begin
            if (cmd_q == CMD_UNMAP) begin
              status_d = STAT_NOT_MAPPED;
            end
            state_d = S_DONE;
          end
        end else begin
          case (cmd_q)
            CMD_MAP: begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, frame_q};
            end
            CMD_UNMAP: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            default: begin
              mapped_d = mem_rdata[PRESENT_BIT];
            end
          endcase
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_mapped_d = mapped_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_q      <= FREE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    vpage_q      <= vpage_d;
    frame_q      <= frame_d;
    level_q      <= level_d;
    page_q       <= page_d;
    addr_q       <= addr_d;
    status_q     <= status_d;
    mapped_q     <= mapped_d;
    out_status_q <= out_status_d;
    out_mapped_q <= out_mapped_d;
  end

endmodule

`default_nettype wire
